@@ rtl/core/ska_pkg.sv @@
// shared types and constants for the sprite keyframe animator
package ska_pkg;

  localparam int MaxNodes  = 16;
  localparam int MaxFrames = 16;
  localparam int FracBits  = 16;
  localparam int OffBits   = FracBits + 24;
  localparam int StepBits  = FracBits + 18;
  localparam int IdxBits   = 4;
  localparam int DivBits   = 17 + FracBits;  // magnitude of delta shifted
  localparam int NodeW     = 48;
  localparam int FrameW    = 80;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpNode  = 2'd1,
    OpFrame = 2'd2,
    OpStart = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RegNodeCount   = 3'd0,
    RegFrameCount  = 3'd1,
    RegMotionEn    = 3'd2,
    RegAnimEn      = 3'd3,
    RegWorldX      = 3'd4,
    RegWorldY      = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StExec,
    StDiv,
    StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       exec;       // apply the accepted word
    logic       div_start;  // begin step division
    logic       out_load;   // capture result word
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic       need_div;
    logic       div_busy;
  } sts_t;

endpackage

@@ rtl/core/ska_ram.sv @@
// generic single port write, single port registered read ram
module ska_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/core/ska_div.sv @@
// serial restoring divider for the signed motion step
module ska_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [16:0]                delta_i,
  input  logic [15:0]                       cnt_i,
  output logic                              busy_o,
  output logic signed [ska_pkg::StepBits-1:0] step_o
);
  import ska_pkg::*;

  localparam int CntW = $clog2(DivBits + 1);

  logic [DivBits-1:0] quo_q, quo_d;
  logic [16:0]        rem_q, rem_d;
  logic [15:0]        den_q, den_d;
  logic               neg_q, neg_d;
  logic               zero_q, zero_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [16:0]        mag;
  logic [17:0]        trial;
  logic [StepBits-1:0] qext;

  assign mag = delta_i[16] ? 17'(-delta_i) : 17'(delta_i);
  assign trial = {rem_q, quo_q[DivBits-1]} - {2'b0, den_q};

  // one quotient bit per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = {mag, {FracBits{1'b0}}};
      rem_d  = '0;
      den_d  = cnt_i;
      neg_d  = delta_i[16];
      zero_d = (cnt_i == 16'd0);
      cnt_d  = CntW'(DivBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[DivBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], quo_q[DivBits-1]};
        quo_d = {quo_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign qext   = StepBits'(quo_q);
  assign busy_o = busy_q;
  assign step_o = zero_q ? '0 : (neg_q ? -$signed(qext) : $signed(qext));
endmodule

@@ rtl/core/ska_datapath.sv @@
// tables, counters, offset accumulators and result register
module ska_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ska_pkg::ctl_t         ctl_i,
  output ska_pkg::sts_t         sts_o,
  input  logic                  in_accept_i,
  input  logic [1:0]            op_i,
  input  logic [3:0]            entry_index_i,
  input  logic signed [15:0]    val_a_i,
  input  logic signed [15:0]    val_b_i,
  input  logic [15:0]           val_c_i,
  input  logic [15:0]           val_d_i,
  input  logic [15:0]           val_e_i,
  input  logic signed [15:0]    camera_x_i,
  input  logic signed [15:0]    camera_y_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  output logic signed [17:0]    screen_x_o,
  output logic signed [17:0]    screen_y_o,
  output logic signed [15:0]    rect_left_o,
  output logic signed [15:0]    rect_top_o,
  output logic [15:0]           rect_width_o,
  output logic [15:0]           rect_height_o,
  output logic [3:0]            frame_now_o,
  output logic [3:0]            node_now_o
);
  import ska_pkg::*;

  // captured item
  logic [1:0]         op_q;
  logic [3:0]         idx_q;
  logic signed [15:0] a_q, b_q, cx_q, cy_q;
  logic [15:0]        c_q, d_q, e_q;

  // configuration
  logic [4:0]         node_count_q, frame_count_q;
  logic               motion_en_q, anim_en_q;
  logic signed [15:0] world_x_q, world_y_q;

  // script state
  logic               anim_act_q, motion_act_q;
  logic [3:0]         cur_frame_q, cur_node_q;
  logic [15:0]        frame_ticks_q, node_ticks_q;
  logic [OffBits-1:0] off_x_q, off_y_q;

  // divider operands held for the y pass
  logic signed [16:0] dy_q;
  logic [15:0]        dcnt_q;
  logic               div_y_q;
  logic signed [StepBits-1:0] step_x_q, step_y_q;
  logic               need_div_q;

  // table ports
  logic [NodeW-1:0]   cur_node_rd, nxt_node_rd, node0_rd;
  logic [FrameW-1:0]  frame_rd;
  logic               node_we, frame_we;
  logic [3:0]         nxt_node_idx, cur_frame_sel;

  assign node_we  = ctl_i.exec && (op_q == OpNode);
  assign frame_we = ctl_i.exec && (op_q == OpFrame);

  // next node index with wrap
  always_comb begin
    nxt_node_idx = cur_node_q + 4'd1;
    if ({1'b0, cur_node_q} + 5'd1 >= node_count_q || cur_node_q == 4'(MaxNodes - 1)) begin
      nxt_node_idx = '0;
    end
  end

  // frame read address follows the live frame pointer
  assign cur_frame_sel = cur_frame_q;

  ska_ram #(.Width(NodeW), .Depth(MaxNodes)) u_node_cur (
    .clk_i, .we_i(node_we), .waddr_i(idx_q), .wdata_i({a_q, b_q, c_q}),
    .raddr_i(cur_node_q), .rdata_o(cur_node_rd)
  );
  ska_ram #(.Width(NodeW), .Depth(MaxNodes)) u_node_nxt (
    .clk_i, .we_i(node_we), .waddr_i(idx_q), .wdata_i({a_q, b_q, c_q}),
    .raddr_i(nxt_node_idx), .rdata_o(nxt_node_rd)
  );
  ska_ram #(.Width(NodeW), .Depth(MaxNodes)) u_node_zero (
    .clk_i, .we_i(node_we), .waddr_i(idx_q), .wdata_i({a_q, b_q, c_q}),
    .raddr_i(4'd0), .rdata_o(node0_rd)
  );
  ska_ram #(.Width(FrameW), .Depth(MaxFrames)) u_frame (
    .clk_i, .we_i(frame_we), .waddr_i(idx_q),
    .wdata_i({a_q, b_q, c_q, d_q, e_q}),
    .raddr_i(cur_frame_sel), .rdata_o(frame_rd)
  );

  // node fields
  logic signed [15:0] cn_x, cn_y, nn_x, nn_y, n0_x, n0_y;
  logic [15:0]        cn_cnt, nn_cnt, n0_cnt, fr_hold;
  assign {cn_x, cn_y, cn_cnt} = cur_node_rd;
  assign {nn_x, nn_y, nn_cnt} = nxt_node_rd;
  assign {n0_x, n0_y, n0_cnt} = node0_rd;
  assign fr_hold = frame_rd[15:0];

  // divider shared between x and y
  logic               div_start;
  logic signed [16:0] div_delta;
  logic [15:0]        div_cnt;
  logic               div_busy;
  logic signed [StepBits-1:0] div_step;
  logic               div_busy_q;

  ska_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .delta_i(div_delta), .cnt_i(div_cnt),
    .busy_o(div_busy), .step_o(div_step)
  );

  // x pass starts from controller, y pass chains off it
  // table reads are registered and lag the node pointer, so the new node is the wrap test
  logic signed [16:0] dx_w, dy_w;
  logic [15:0]        dcnt_w;
  logic               wrap_w;
  assign wrap_w = (cur_node_q == 4'd0);
  always_comb begin
    if (op_q == OpStart || wrap_w) begin
      dx_w = 17'(n0_x);
      dy_w = 17'(n0_y);
      dcnt_w = n0_cnt;
    end else begin
      dx_w = 17'(nn_x) - 17'(cn_x);
      dy_w = 17'(nn_y) - 17'(cn_y);
      dcnt_w = nn_cnt;
    end
  end

  logic y_go;
  assign y_go      = div_busy_q && !div_busy && !div_y_q;
  assign div_start = ctl_i.div_start || y_go;
  assign div_delta = ctl_i.div_start ? dx_w : dy_q;
  assign div_cnt   = ctl_i.div_start ? dcnt_w : dcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_y_q    <= 1'b0;
      step_x_q   <= '0;
      step_y_q   <= '0;
    end else begin
      div_busy_q <= div_busy;
      if (ctl_i.div_start) begin
        div_y_q <= 1'b0;
      end else if (y_go) begin
        div_y_q  <= 1'b1;
        step_x_q <= div_step;
      end else if (div_busy_q && !div_busy && div_y_q) begin
        step_y_q <= div_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      dy_q   <= dy_w;
      dcnt_q <= dcnt_w;
    end
  end

  assign sts_o.div_busy = div_busy || div_busy_q || div_start;
  assign sts_o.need_div = need_div_q;

  // capture item
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      op_q  <= op_i;
      idx_q <= entry_index_i;
      a_q   <= val_a_i;
      b_q   <= val_b_i;
      c_q   <= val_c_i;
      d_q   <= val_d_i;
      e_q   <= val_e_i;
      cx_q  <= camera_x_i;
      cy_q  <= camera_y_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= 5'd1;
      frame_count_q <= 5'd1;
      motion_en_q   <= 1'b0;
      anim_en_q     <= 1'b0;
      world_x_q     <= '0;
      world_y_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegNodeCount:  node_count_q  <= cfg_data_i[4:0];
        RegFrameCount: frame_count_q <= cfg_data_i[4:0];
        RegMotionEn:   motion_en_q   <= cfg_data_i[0];
        RegAnimEn:     anim_en_q     <= cfg_data_i[0];
        RegWorldX:     world_x_q     <= cfg_data_i;
        RegWorldY:     world_y_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sign extended step added to offset
  logic [OffBits-1:0] sx_ext, sy_ext;
  assign sx_ext = OffBits'(step_x_q);
  assign sy_ext = OffBits'(step_y_q);

  logic [3:0] nxt_frame;
  always_comb begin
    nxt_frame = cur_frame_q + 4'd1;
    if ({1'b0, cur_frame_q} + 5'd1 >= frame_count_q || cur_frame_q == 4'(MaxFrames - 1)) begin
      nxt_frame = '0;
    end
  end

  // execute the item on the script state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anim_act_q    <= 1'b0;
      motion_act_q  <= 1'b0;
      cur_frame_q   <= '0;
      cur_node_q    <= '0;
      frame_ticks_q <= '0;
      node_ticks_q  <= '0;
      off_x_q       <= '0;
      off_y_q       <= '0;
      need_div_q    <= 1'b0;
    end else if (ctl_i.exec) begin
      need_div_q <= 1'b0;
      case (op_q)
        OpTick: begin
          if (anim_act_q) begin
            if (frame_ticks_q == fr_hold) begin
              frame_ticks_q <= '0;
              cur_frame_q   <= nxt_frame;
            end else begin
              frame_ticks_q <= frame_ticks_q + 16'd1;
            end
          end
          if (motion_act_q) begin
            if (node_ticks_q == cn_cnt) begin
              node_ticks_q <= '0;
              cur_node_q   <= nxt_node_idx;
              need_div_q   <= 1'b1;
            end else begin
              off_x_q      <= off_x_q + sx_ext;
              off_y_q      <= off_y_q + sy_ext;
              node_ticks_q <= node_ticks_q + 16'd1;
            end
          end
        end
        OpStart: begin
          anim_act_q   <= anim_en_q;
          motion_act_q <= motion_en_q;
          if (anim_en_q) begin
            cur_frame_q   <= '0;
            frame_ticks_q <= '0;
          end
          if (motion_en_q) begin
            cur_node_q   <= '0;
            node_ticks_q <= '0;
            off_x_q      <= '0;
            off_y_q      <= '0;
            need_div_q   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // round half away from zero
  function automatic logic signed [17:0] round_off(input logic [OffBits-1:0] off);
    logic [OffBits-1:0] mag;
    logic [OffBits-1:0] r;
    mag = off[OffBits-1] ? -off : off;
    r   = (mag + (OffBits'(1) << (FracBits - 1))) >> FracBits;
    round_off = off[OffBits-1] ? -18'(r) : 18'(r);
  endfunction

  logic signed [17:0] rx, ry;
  assign rx = round_off(off_x_q);
  assign ry = round_off(off_y_q);

  // result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      screen_x_o    <= 18'(world_x_q) - 18'(cx_q) + rx;
      screen_y_o    <= 18'(world_y_q) - 18'(cy_q) + ry;
      rect_left_o   <= frame_rd[79:64];
      rect_top_o    <= frame_rd[63:48];
      rect_width_o  <= frame_rd[47:32];
      rect_height_o <= frame_rd[31:16];
      frame_now_o   <= cur_frame_q;
      node_now_o    <= cur_node_q;
    end
  end

  // the y pass always follows the x pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_go |=> div_busy) else $error("y division did not start");
  // no execution while the divider runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.exec |-> !div_busy) else $error("exec during division");
  // tick counters only move on an executed item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(ctl_i.exec) |-> $stable(node_ticks_q)) else $error("stray node tick");
endmodule

@@ rtl/core/ska_ctrl.sv @@
// sequencing state machine for one item at a time
module ska_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ska_pkg::ctl_t ctl_o,
  input  ska_pkg::sts_t sts_i
);
  import ska_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   div_wait_q, div_wait_d;

  // next state
  always_comb begin
    state_d    = state_q;
    div_wait_d = div_wait_q;
    case (state_q)
      StIdle: if (in_valid_i && in_ready_o) state_d = StRead;
      StRead: state_d = StExec;
      StExec: state_d = StDiv;
      StDiv: begin
        if (sts_i.need_div && !div_wait_q) begin
          div_wait_d = 1'b1;
        end else if (!sts_i.div_busy) begin
          div_wait_d = 1'b0;
          state_d = StOut;
        end
      end
      StOut: if (!ov_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o = '0;
    ov_d  = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      StExec:  ctl_o.exec = 1'b1;
      StDiv:   ctl_o.div_start = sts_i.need_div && !div_wait_q;
      StOut: begin
        if (!ov_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          ov_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ov_q       <= 1'b0;
      div_wait_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ov_q       <= ov_d;
      div_wait_q <= div_wait_d;
    end
  end

  // a result is loaded only from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |-> state_q == StOut) else $error("stray result load");
  // accept leads to a table read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == StRead) else $error("missed read");
  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |-> !ctl_o.out_load) else $error("result overwritten");
endmodule

@@ rtl/core/sprite_keyframe_animator.sv @@
// sprite keyframe animator top level
// one item at a time: a table write, a start without motion or a tick
// without node change passes the read, execute, division and output states;
// a node change or motion start adds two serial divisions, x then y,
// on the shared one-bit-per-cycle step divider
// reset clears scripts, counters, offsets and configuration registers; tables are not cleared
module sprite_keyframe_animator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [15:0] val_a_i,
  input  logic signed [15:0] val_b_i,
  input  logic [15:0]        val_c_i,
  input  logic [15:0]        val_d_i,
  input  logic [15:0]        val_e_i,
  input  logic signed [15:0] camera_x_i,
  input  logic signed [15:0] camera_y_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] screen_x_o,
  output logic signed [17:0] screen_y_o,
  output logic signed [15:0] rect_left_o,
  output logic signed [15:0] rect_top_o,
  output logic [15:0]        rect_width_o,
  output logic [15:0]        rect_height_o,
  output logic [3:0]         frame_now_o,
  output logic [3:0]         node_now_o
);
  import ska_pkg::*;

  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ska_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .ctl_o(ctl), .sts_i(sts)
  );

  ska_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts),
    .in_accept_i(in_valid_i && in_ready_o),
    .op_i, .entry_index_i, .val_a_i, .val_b_i, .val_c_i, .val_d_i, .val_e_i,
    .camera_x_i, .camera_y_i,
    .cfg_we_i(cfg_valid_i), .cfg_index_i, .cfg_data_i,
    .screen_x_o, .screen_y_o, .rect_left_o, .rect_top_o, .rect_width_o,
    .rect_height_o, .frame_now_o, .node_now_o
  );
endmodule
